FILE: src/cvs_pkg.sv
// Shared types and constants for the capability variant selector.
// Holds the id field layout, score weights, config register indexes and
// the structs passed between the scoring, tracking and top-level modules.
package cvs_pkg;

    localparam int ID_W      = 8;
    localparam int PTS_W     = 17;
    localparam int INDEX_W   = 8;
    localparam int CFG_IDX_W = 8;

    typedef logic [ID_W-1:0]      id_t;
    typedef logic [PTS_W-1:0]     pts_t;
    typedef logic [INDEX_W-1:0]   index_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Config register indexes
    localparam cfg_idx_t CFG_ORIG_SENTINEL = 8'd0;
    localparam cfg_idx_t CFG_MD_SENTINEL   = 8'd1;

    // Config register reset values
    localparam id_t ORIG_SENTINEL_RST = 8'd12;
    localparam id_t MD_SENTINEL_RST   = 8'd28;

    // Field codes
    localparam logic [1:0] FMT_ORIGINAL  = 2'd0;
    localparam logic [1:0] FMT_SVG       = 2'd3;
    localparam logic [1:0] VIEW_SENTINEL = 2'd3;
    localparam logic [1:0] ENC_IDENTITY  = 2'd0;

    // Score weights
    localparam pts_t PTS_SVG         = 17'd1200;
    localparam pts_t PTS_FMT_MATCH   = 17'd1000;
    localparam pts_t PTS_FMT_ORIG    = 17'd100;
    localparam pts_t PTS_VIEW        = 17'd80;
    localparam pts_t PTS_DENS        = 17'd40;
    localparam pts_t PTS_SAVE_SVG    = 17'd50;
    localparam pts_t PTS_SAVE        = 17'd20;
    localparam pts_t PTS_ENC         = 17'd60;
    localparam pts_t PTS_ENC_IDENT   = 17'd5;
    localparam pts_t PTS_MAX_ORDINARY = 17'd1430;
    localparam pts_t MARKDOWN_POINTS = 17'd100000;

    // Scoring verdict for one id
    typedef struct packed {
        pts_t points;    // ordinary score, 0 when disqualified
        logic sentinel;  // viewport bits mark a sentinel id
        logic md_hit;    // agent request for the markdown sentinel
    } score_t;

    // Result word contents
    typedef struct packed {
        logic   found;
        index_t index;
        pts_t   points;
    } result_t;

endpackage

FILE: src/cvs_score.sv
// Combinational scorer: rates one variant id against the request mask.
// Depends on cvs_pkg for field codes, weights and the score_t struct.
module cvs_score
    import cvs_pkg::*;
(
    input  id_t    variant_id,
    input  id_t    req_mask,
    input  logic   is_agent,
    input  id_t    orig_sentinel,
    input  id_t    md_sentinel,
    output score_t score
);

    logic svg;
    logic fmt_ok;
    logic enc_ok;
    pts_t fmt_pts;
    pts_t view_pts;
    pts_t dens_pts;
    pts_t save_pts;
    pts_t enc_pts;

    assign svg = (variant_id[1:0] == FMT_SVG);

    // Format: SVG always fits, else exact match, else original-format fallback
    always_comb
    begin
        fmt_ok  = 1'b1;
        fmt_pts = '0;
        if (svg)
        begin
            fmt_pts = PTS_SVG;
        end
        else if (req_mask[1:0] == variant_id[1:0])
        begin
            fmt_pts = PTS_FMT_MATCH;
        end
        else if (variant_id[1:0] == FMT_ORIGINAL)
        begin
            fmt_pts = PTS_FMT_ORIG;
        end
        else
        begin
            fmt_ok = 1'b0;
        end
    end

    // Viewport, density and save-data bonuses
    assign view_pts = (svg || req_mask[3:2] == variant_id[3:2]) ? PTS_VIEW : '0;
    assign dens_pts = (svg || req_mask[4] == variant_id[4]) ? PTS_DENS : '0;

    always_comb
    begin
        if (svg && req_mask[5])
        begin
            save_pts = PTS_SAVE_SVG;
        end
        else if (req_mask[5] == variant_id[5])
        begin
            save_pts = PTS_SAVE;
        end
        else
        begin
            save_pts = '0;
        end
    end

    // Encoding: match, else identity, else disqualified
    always_comb
    begin
        enc_ok  = 1'b1;
        enc_pts = '0;
        if (req_mask[7:6] == variant_id[7:6])
        begin
            enc_pts = PTS_ENC;
        end
        else if (variant_id[7:6] == ENC_IDENTITY)
        begin
            enc_pts = PTS_ENC_IDENT;
        end
        else
        begin
            enc_ok = 1'b0;
        end
    end

    // Sum the terms and classify sentinels
    always_comb
    begin
        score.points   = (fmt_ok && enc_ok)
                       ? (fmt_pts + view_pts + dens_pts + save_pts + enc_pts) : '0;
        score.sentinel = (variant_id[3:2] == VIEW_SENTINEL);
        score.md_hit   = (variant_id != orig_sentinel) && is_agent
                       && (variant_id == md_sentinel);
    end

endmodule

FILE: src/cvs_track.sv
// Running-best tracker and result register for the variant selector.
// Depends on cvs_pkg; takes the score_t verdict from cvs_score.
module cvs_track
    import cvs_pkg::*;
#(
    parameter int MAX_VARIANTS = 256
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    proc,
    input  id_t     item_id,
    input  logic    item_last,
    input  score_t  score,
    input  logic    out_take,
    output logic    out_valid,
    output result_t result
);

    localparam int PW = $clog2(MAX_VARIANTS);
    localparam logic [PW-1:0] POS_LAST = PW'(MAX_VARIANTS - 1);

    pts_t          best_points_reg;
    logic [PW-1:0] best_pos_reg;
    id_t           best_id_reg;
    logic          have_best_reg;
    logic [PW-1:0] pos_cnt_reg;
    logic          out_valid_reg;
    result_t       result_reg;

    pts_t          best_points_next;
    logic [PW-1:0] best_pos_next;
    id_t           best_id_next;
    logic          have_best_next;
    logic [PW-1:0] pos_cnt_next;
    result_t       result_next;
    logic          win;
    logic          tie_win;
    logic [PW+INDEX_W-1:0] pos_ext;

    // Compare this item against the running best
    always_comb
    begin
        best_points_next = best_points_reg;
        best_pos_next    = best_pos_reg;
        best_id_next     = best_id_reg;
        have_best_next   = have_best_reg;
        win              = 1'b0;
        tie_win          = 1'b0;
        if (score.sentinel)
        begin
            if (score.md_hit && (MARKDOWN_POINTS > best_points_reg))
            begin
                best_points_next = MARKDOWN_POINTS;
                best_pos_next    = pos_cnt_reg;
                have_best_next   = 1'b1;
            end
        end
        else
        begin
            win     = score.points > best_points_reg;
            tie_win = have_best_reg && (score.points == best_points_reg)
                    && ((item_id[1:0] > best_id_reg[1:0])
                        || ((item_id[1:0] == best_id_reg[1:0]) && (item_id > best_id_reg)));
            if (win || tie_win)
            begin
                best_points_next = score.points;
                best_pos_next    = pos_cnt_reg;
                best_id_next     = item_id;
                have_best_next   = 1'b1;
            end
        end
    end

    // Advance the list position, wrapping at the list depth
    assign pos_cnt_next = (pos_cnt_reg == POS_LAST) ? '0 : pos_cnt_reg + 1'b1;

    // Build the result word from the updated best
    assign pos_ext = {{INDEX_W{1'b0}}, best_pos_next};

    always_comb
    begin
        result_next.found  = have_best_next;
        result_next.index  = have_best_next ? pos_ext[INDEX_W-1:0] : '0;
        result_next.points = have_best_next ? best_points_next : '0;
    end

    // Hold the running best; clear it after the last item of a list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_points_reg <= '0;
            best_pos_reg    <= '0;
            best_id_reg     <= '0;
            have_best_reg   <= 1'b0;
            pos_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (proc)
            begin
                if (item_last)
                begin
                    best_points_reg <= '0;
                    best_pos_reg    <= '0;
                    best_id_reg     <= '0;
                    have_best_reg   <= 1'b0;
                    pos_cnt_reg     <= '0;
                end
                else
                begin
                    best_points_reg <= best_points_next;
                    best_pos_reg    <= best_pos_next;
                    best_id_reg     <= best_id_next;
                    have_best_reg   <= have_best_next;
                    pos_cnt_reg     <= pos_cnt_next;
                end
            end
            if (proc && item_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result word on the last item
    always_ff @(posedge clk)
    begin
        if (proc && item_last)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

`ifndef SYNTHESIS
    a_best_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        have_best_reg |-> (best_points_reg != '0))
        else $error("running best held with zero score");

    a_idle_best_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !have_best_reg |-> (best_points_reg == '0 && best_pos_reg == '0))
        else $error("stale best without a selection");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && item_last) |=> (pos_cnt_reg == '0 && !have_best_reg && out_valid_reg))
        else $error("list state not cleared after last word");

    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        (best_points_reg == MARKDOWN_POINTS) || (best_points_reg <= PTS_MAX_ORDINARY))
        else $error("best score out of range");
`endif

endmodule

FILE: src/capability_variant_selector.sv
// Top level of the capability variant selector: input register, config
// registers and stream handshakes. Depends on cvs_pkg, cvs_score, cvs_track.
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tdata: variant_id, req_mask; tuser: is_agent;
//                                     tlast: is_last
// m_*       out  m_tvalid/m_tready    tdata: best_index, best_points; tuser: found
// cfg_*     in   cfg_valid/cfg_ready  cfg_index: register index; cfg_data: value
//
// One word per cycle in unless a last word stalls; each word waits in the input
// register and is scored and folded into the running best as it leaves it.
// A result is loaded into the result register as its last word leaves the input register.
// Only a last word waits on a full result register; other words pass it.
// rst_n clears control state asynchronously and restores the sentinel ids.
module capability_variant_selector
    import cvs_pkg::*;
#(
    parameter int MAX_VARIANTS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] variant_id, [15:8] req_mask
    input  logic        s_tuser,   // [0] is_agent
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] best_index, [24:8] best_points, [31:25] zero
    output logic        m_tuser,   // [0] found
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_idx_t    cfg_index,
    input  id_t         cfg_data
);

    id_t     orig_sentinel_reg;
    id_t     md_sentinel_reg;
    logic    in_valid_reg;
    id_t     in_id_reg;
    id_t     in_mask_reg;
    logic    in_agent_reg;
    logic    in_last_reg;
    logic    accept;
    logic    proc;
    logic    out_free;
    logic    out_valid;
    score_t  score;
    result_t result;

    // Config writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orig_sentinel_reg <= ORIG_SENTINEL_RST;
            md_sentinel_reg   <= MD_SENTINEL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ORIG_SENTINEL: orig_sentinel_reg <= cfg_data;
                CFG_MD_SENTINEL:   md_sentinel_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Handshake: a last word needs room in the result register
    assign out_free = !out_valid || m_tready;
    assign proc     = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || proc;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_id_reg    <= s_tdata[7:0];
            in_mask_reg  <= s_tdata[15:8];
            in_agent_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    cvs_score u_score (
        .variant_id    (in_id_reg),
        .req_mask      (in_mask_reg),
        .is_agent      (in_agent_reg),
        .orig_sentinel (orig_sentinel_reg),
        .md_sentinel   (md_sentinel_reg),
        .score         (score)
    );

    cvs_track #(
        .MAX_VARIANTS (MAX_VARIANTS)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .proc      (proc),
        .item_id   (in_id_reg),
        .item_last (in_last_reg),
        .score     (score),
        .out_take  (m_tready),
        .out_valid (out_valid),
        .result    (result)
    );

    // Pack the result word
    assign m_tvalid = out_valid;
    assign m_tuser  = result.found;
    assign m_tdata  = {7'd0, result.points, result.index};

endmodule
